>>> rtl/onenc_pkg.sv
`timescale 1ns / 1ps

package onenc_pkg;

  // control that travels with each beat down the pipeline
  typedef struct packed {
    logic valid;
    logic zero;
  } onenc_ctl_t;

  // quotient bits handled per divider stage, the last stage taking the rest
  localparam int StepsPerStage = 3;

endpackage

>>> rtl/octahedral_normal_encode.sv
// pipeline: front end, restoring divider stages and a rounding register from accept to result
// throughput: one beat per cycle; the whole pipe advances together and holds on out_stall
// the divider is restoring, up to three quotient bits per stage per coordinate
// reset: rst is synchronous, active high, and clears every valid bit; no payload is reset
`timescale 1ns / 1ps

module octahedral_normal_encode #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRACTION_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COMPONENT_WIDTH-1:0] dir_x,
  input  logic signed [COMPONENT_WIDTH-1:0] dir_y,
  input  logic signed [COMPONENT_WIDTH-1:0] dir_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic        [FRACTION_BITS-1:0]   enc_u,
  output logic        [FRACTION_BITS-1:0]   enc_v,
  output logic                              zero_vector
);

  // divisor 2s needs two bits over a component, remainder one more
  localparam int DW  = COMPONENT_WIDTH + 2;
  localparam int RW  = DW + 1;
  // integer bit, fraction bits and one guard bit for rounding
  localparam int QB  = FRACTION_BITS + 2;
  localparam int SPS = onenc_pkg::StepsPerStage;
  localparam int NST = (QB + SPS - 1) / SPS;

  // the pipe moves unless a finished beat is held at the output
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // per-stage payload between the front end, the divider stages and rounding
  onenc_pkg::onenc_ctl_t ctl_s [NST+1];
  logic [RW-1:0]         ru_s  [NST+1];
  logic [RW-1:0]         rv_s  [NST+1];
  logic [QB-1:0]         qu_s  [NST+1];
  logic [QB-1:0]         qv_s  [NST+1];
  logic [DW-1:0]         d_s   [NST+1];

  logic [DW-1:0] nu;
  logic [DW-1:0] nv;

  // two stages: component magnitudes, then the numerators and 2s
  onenc_front #(
    .CW (COMPONENT_WIDTH),
    .DW (DW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (in_valid),
    .dir_x    (dir_x),
    .dir_y    (dir_y),
    .dir_z    (dir_z),
    .ctl      (ctl_s[0]),
    .nu       (nu),
    .nv       (nv),
    .d        (d_s[0])
  );

  // numerators never exceed 2s, so they start as the remainder
  assign ru_s[0] = {1'b0, nu};
  assign rv_s[0] = {1'b0, nv};
  assign qu_s[0] = '0;
  assign qv_s[0] = '0;

  // divider chain; the last stage takes whatever bits are left
  for (genvar g = 0; g < NST; g++) begin : g_div
    localparam int NS = (g == NST - 1) ? (QB - SPS * (NST - 1)) : SPS;
    onenc_div_stage #(
      .DW     (DW),
      .QB     (QB),
      .NSTEPS (NS)
    ) u_div (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .ctl_in (ctl_s[g]),
      .ru_in  (ru_s[g]),
      .rv_in  (rv_s[g]),
      .qu_in  (qu_s[g]),
      .qv_in  (qv_s[g]),
      .d_in   (d_s[g]),
      .ctl    (ctl_s[g+1]),
      .ru     (ru_s[g+1]),
      .rv     (rv_s[g+1]),
      .qu     (qu_s[g+1]),
      .qv     (qv_s[g+1]),
      .d      (d_s[g+1])
    );
  end

  // round half up, saturate full scale, force zero for a null vector
  onenc_round #(
    .QB (QB),
    .FB (FRACTION_BITS)
  ) u_round (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .ctl_in      (ctl_s[NST]),
    .qu_in       (qu_s[NST]),
    .qv_in       (qv_s[NST]),
    .out_valid   (out_valid),
    .enc_u       (enc_u),
    .enc_v       (enc_v),
    .zero_vector (zero_vector)
  );

  // a null vector leaves with both coordinates cleared
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_vector |-> enc_u == '0 && enc_v == '0)
    else $error("zero vector with nonzero coordinates");

  // input is held back only by a waiting result
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // a held result is still there and unchanged in the next cycle
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(enc_u) && $stable(enc_v))
    else $error("held result changed");

endmodule

>>> rtl/onenc_front.sv
`timescale 1ns / 1ps

module onenc_front #(
  parameter int CW = 16,
  parameter int DW = CW + 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic signed [CW-1:0]    dir_x,
  input  logic signed [CW-1:0]    dir_y,
  input  logic signed [CW-1:0]    dir_z,
  output onenc_pkg::onenc_ctl_t   ctl,
  output logic        [DW-1:0]    nu,
  output logic        [DW-1:0]    nv,
  output logic        [DW-1:0]    d
);

  // stage one: magnitudes and signs
  onenc_pkg::onenc_ctl_t ctl1;
  logic [CW-1:0] ax;
  logic [CW-1:0] ay;
  logic [CW-1:0] az;
  logic          xneg;
  logic          yneg;
  logic          zneg;

  logic [CW-1:0] ax_next;
  logic [CW-1:0] ay_next;
  logic [CW-1:0] az_next;

  assign ax_next = dir_x[CW-1] ? (~dir_x + CW'(1)) : dir_x;
  assign ay_next = dir_y[CW-1] ? (~dir_y + CW'(1)) : dir_y;
  assign az_next = dir_z[CW-1] ? (~dir_z + CW'(1)) : dir_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else if (adv) begin
      ctl1.valid <= in_valid;
      ctl1.zero  <= (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax   <= ax_next;
      ay   <= ay_next;
      az   <= az_next;
      xneg <= dir_x[CW-1];
      yneg <= dir_y[CW-1];
      zneg <= dir_z[CW-1];
    end
  end

  // stage two: numerators as sums of up to three magnitude terms
  logic [DW-1:0] ex1;
  logic [DW-1:0] ey1;
  logic [DW-1:0] ez1;
  logic [DW-1:0] ex2;
  logic [DW-1:0] ey2;
  logic [DW-1:0] ez2;
  logic [DW-1:0] nu_next;
  logic [DW-1:0] nv_next;
  logic [DW-1:0] d_next;

  assign ex1 = {2'b00, ax};
  assign ey1 = {2'b00, ay};
  assign ez1 = {2'b00, az};
  assign ex2 = {1'b0, ax, 1'b0};
  assign ey2 = {1'b0, ay, 1'b0};
  assign ez2 = {1'b0, az, 1'b0};

  assign d_next = ex2 + ey2 + ez2;

  always_comb begin
    if (yneg) begin
      // folded: 2s - |z| for x >= 0, else |z|
      nu_next = xneg ? ez1 : (ex2 + ey2 + ez1);
      // folded: 2s - |x| only for z < 0, z = 0 takes the |x| branch
      nv_next = zneg ? (ex1 + ey2 + ez2) : ex1;
    end else begin
      // s + x
      nu_next = xneg ? (ey1 + ez1) : (ex2 + ey1 + ez1);
      // s - z
      nv_next = zneg ? (ex1 + ey1 + ez2) : (ex1 + ey1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (adv) begin
      ctl <= ctl1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nu <= nu_next;
      nv <= nv_next;
      d  <= d_next;
    end
  end

endmodule

>>> rtl/onenc_div_stage.sv
`timescale 1ns / 1ps

module onenc_div_stage #(
  parameter int DW     = 18,
  parameter int QB     = 18,
  parameter int NSTEPS = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  onenc_pkg::onenc_ctl_t ctl_in,
  input  logic [DW:0]           ru_in,
  input  logic [DW:0]           rv_in,
  input  logic [QB-1:0]         qu_in,
  input  logic [QB-1:0]         qv_in,
  input  logic [DW-1:0]         d_in,
  output onenc_pkg::onenc_ctl_t ctl,
  output logic [DW:0]           ru,
  output logic [DW:0]           rv,
  output logic [QB-1:0]         qu,
  output logic [QB-1:0]         qv,
  output logic [DW-1:0]         d
);

  localparam int RW = DW + 1;

  logic [RW-1:0] dx;
  logic [RW-1:0] ru_next;
  logic [RW-1:0] rv_next;
  logic [QB-1:0] qu_next;
  logic [QB-1:0] qv_next;

  assign dx = {1'b0, d_in};

  // restoring steps: compare, subtract, then shift for the next bit
  always_comb begin
    ru_next = ru_in;
    rv_next = rv_in;
    qu_next = qu_in;
    qv_next = qv_in;
    for (int i = 0; i < NSTEPS; i++) begin
      if (ru_next >= dx) begin
        ru_next = ru_next - dx;
        qu_next = {qu_next[QB-2:0], 1'b1};
      end else begin
        qu_next = {qu_next[QB-2:0], 1'b0};
      end
      if (rv_next >= dx) begin
        rv_next = rv_next - dx;
        qv_next = {qv_next[QB-2:0], 1'b1};
      end else begin
        qv_next = {qv_next[QB-2:0], 1'b0};
      end
      ru_next = {ru_next[RW-2:0], 1'b0};
      rv_next = {rv_next[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (adv) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ru <= ru_next;
      rv <= rv_next;
      qu <= qu_next;
      qv <= qv_next;
      d  <= d_in;
    end
  end

  // shifted remainder stays below twice the divisor
  a_ru_bound: assert property (@(posedge clk) disable iff (rst)
    ctl.valid && !ctl.zero |-> ru < {d, 1'b0})
    else $error("u remainder out of range");

  a_rv_bound: assert property (@(posedge clk) disable iff (rst)
    ctl.valid && !ctl.zero |-> rv < {d, 1'b0})
    else $error("v remainder out of range");

endmodule

>>> rtl/onenc_round.sv
`timescale 1ns / 1ps

module onenc_round #(
  parameter int QB = 18,
  parameter int FB = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  onenc_pkg::onenc_ctl_t ctl_in,
  input  logic [QB-1:0]         qu_in,
  input  logic [QB-1:0]         qv_in,
  output logic                  out_valid,
  output logic [FB-1:0]         enc_u,
  output logic [FB-1:0]         enc_v,
  output logic                  zero_vector
);

  logic [QB-1:0] qu_inc;
  logic [QB-1:0] qv_inc;
  logic [FB:0]   ru;
  logic [FB:0]   rv;
  logic [FB-1:0] enc_u_next;
  logic [FB-1:0] enc_v_next;

  // half up: add one at the guard bit and drop it
  assign qu_inc = qu_in + QB'(1);
  assign qv_inc = qv_in + QB'(1);
  assign ru     = qu_inc[QB-1:1];
  assign rv     = qv_inc[QB-1:1];

  always_comb begin
    if (ctl_in.zero) begin
      enc_u_next = '0;
      enc_v_next = '0;
    end else begin
      enc_u_next = ru[FB] ? {FB{1'b1}} : ru[FB-1:0];
      enc_v_next = rv[FB] ? {FB{1'b1}} : rv[FB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      enc_u       <= enc_u_next;
      enc_v       <= enc_v_next;
      zero_vector <= ctl_in.zero;
    end
  end

endmodule
